FILE: rtl/hashed_key_lru_result_cache_macros.svh
// Assertion macros for the hashed key LRU result cache checker.
`ifndef HASHED_KEY_LRU_RESULT_CACHE_MACROS_SVH
`define HASHED_KEY_LRU_RESULT_CACHE_MACROS_SVH

// Same-cycle implication.
`define HKLC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define HKLC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/hklc_pkg.sv
// Shared constants and types for the hashed key LRU result cache.
package hklc_pkg;

  localparam int WORD_W      = 32;
  localparam int SLOT_OUT_W  = 4;
  localparam int OCC_OUT_W   = 5;
  localparam int IDX_EXT_W   = 8;
  localparam int CNT_EXT_W   = 9;
  localparam int VALUE_EXT_W = 64;

  localparam logic [WORD_W-1:0] HASH_SEED  = 32'd5381;
  localparam int                HASH_SHIFT = 5;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_HIT    = 3'd1,
    CMD_UPDATE = 3'd2,
    CMD_FILL   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_kind_t;

endpackage

FILE: rtl/hklc_cell.sv
// One table entry with its stage of the search chain.
module hklc_cell #(
  parameter int  ENTRIES     = 16,
  parameter int  VALUE_WIDTH = 32,
  parameter int  SLOT        = 0,
  parameter type tok_t       = logic,
  parameter type cmd_t       = logic
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [hklc_pkg::WORD_W-1:0] key_i,
  input  tok_t                      tok_i,
  output tok_t                      tok_o,
  input  cmd_t                      cmd_i
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic                         valid_r, valid_nxt;
  logic [hklc_pkg::WORD_W-1:0]  key_r, key_nxt;
  logic [VALUE_WIDTH-1:0]       value_r, value_nxt;
  logic [hklc_pkg::WORD_W-1:0]  hits_r, hits_nxt;
  logic [hklc_pkg::WORD_W-1:0]  time_r, time_nxt;
  tok_t                         tok_r, tok_nxt;
  logic                         sel;

  assign tok_o = tok_r;
  assign sel   = (cmd_i.slot == IDX_W'(SLOT));

  always_comb begin
    tok_nxt = tok_i;
    if (!tok_i.match && valid_r && (key_r == key_i)) begin
      tok_nxt.match       = 1'b1;
      tok_nxt.match_idx   = IDX_W'(SLOT);
      tok_nxt.match_value = value_r;
      tok_nxt.match_hits  = hits_r;
    end
    if (!tok_i.empty && !valid_r) begin
      tok_nxt.empty     = 1'b1;
      tok_nxt.empty_idx = IDX_W'(SLOT);
    end
    if (time_r < tok_i.old_time) begin
      tok_nxt.old_idx  = IDX_W'(SLOT);
      tok_nxt.old_time = time_r;
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    value_nxt = value_r;
    hits_nxt  = hits_r;
    time_nxt  = time_r;
    unique case (cmd_i.kind)
      hklc_pkg::CMD_CLEAR: begin
        valid_nxt = 1'b0;
        hits_nxt  = '0;
      end
      hklc_pkg::CMD_HIT: begin
        if (sel) begin
          hits_nxt = hits_r + 32'd1;
          time_nxt = cmd_i.tick;
        end
      end
      hklc_pkg::CMD_UPDATE: begin
        if (sel) begin
          value_nxt = cmd_i.value;
          time_nxt  = cmd_i.tick;
        end
      end
      hklc_pkg::CMD_FILL: begin
        if (sel) begin
          valid_nxt = 1'b1;
          key_nxt   = cmd_i.key;
          value_nxt = cmd_i.value;
          hits_nxt  = '0;
          time_nxt  = cmd_i.tick;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      hits_r  <= '0;
      time_r  <= '0;
    end else begin
      valid_r <= valid_nxt;
      hits_r  <= hits_nxt;
      time_r  <= time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r   <= key_nxt;
    value_r <= value_nxt;
    tok_r   <= tok_nxt;
  end

endmodule

FILE: rtl/hashed_key_lru_result_cache.sv
// Hashed key LRU result cache: key bytes are hashed with djb2 (h*33+byte) and the
// finished hash is looked up in or inserted into a fully associative table. A key
// byte that is not the last only updates the running hash. At a key end the search
// token passes through the row of registered entry cells in order, collecting the
// first hash match, the first empty slot and the lowest-index oldest entry, and then
// the apply step applies the update and loads the result register. A clear goes
// straight to the apply step. While the result register is full and stalled, a key
// end waits in the apply step. Key bytes with opcode three are taken and ignored.
module hashed_key_lru_result_cache #(
  parameter int ENTRIES     = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_key_byte,
  input  logic        in_key_last,
  input  logic [31:0] in_result_word,
  input  logic [31:0] in_tick_now,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_hit,
  output logic [31:0] out_stored_word,
  output logic [31:0] out_entry_hit_count,
  output logic [3:0]  out_slot_used,
  output logic [31:0] out_lookups_total,
  output logic [31:0] out_hits_total,
  output logic [31:0] out_misses_total,
  output logic [4:0]  out_occupancy
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int W     = hklc_pkg::WORD_W;

  typedef struct packed {
    logic                   match;
    logic [IDX_W-1:0]       match_idx;
    logic [VALUE_WIDTH-1:0] match_value;
    logic [W-1:0]           match_hits;
    logic                   empty;
    logic [IDX_W-1:0]       empty_idx;
    logic [IDX_W-1:0]       old_idx;
    logic [W-1:0]           old_time;
  } tok_t;

  typedef struct packed {
    hklc_pkg::cmd_kind_t    kind;
    logic [IDX_W-1:0]       slot;
    logic [W-1:0]           key;
    logic [VALUE_WIDTH-1:0] value;
    logic [W-1:0]           tick;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_APPLY  = 3'b100
  } state_t;

  state_t                 state_r, state_nxt;
  logic [W-1:0]           acc_r, acc_nxt;
  logic [W-1:0]           key_r, key_nxt;
  logic                   ins_r, ins_nxt;
  logic                   clr_r, clr_nxt;
  logic [VALUE_WIDTH-1:0] word_r, word_nxt;
  logic [W-1:0]           tick_r, tick_nxt;
  logic [IDX_W-1:0]       cnt_r, cnt_nxt;
  logic [W-1:0]           lookups_r, lookups_nxt;
  logic [W-1:0]           hits_r, hits_nxt;
  logic [W-1:0]           misses_r, misses_nxt;
  logic [CNT_W-1:0]       occ_r, occ_nxt;

  logic                   out_valid_r, out_valid_nxt;
  logic                   out_hit_r, out_hit_nxt;
  logic [W-1:0]           out_word_r, out_word_nxt;
  logic [W-1:0]           out_cnt_r, out_cnt_nxt;
  logic [3:0]             out_slot_r, out_slot_nxt;
  logic [W-1:0]           out_lookups_r;
  logic [W-1:0]           out_hits_r;
  logic [W-1:0]           out_misses_r;
  logic [4:0]             out_occ_r, out_occ_nxt;

  logic [W-1:0]                        hash_new;
  logic [hklc_pkg::VALUE_EXT_W-1:0]    word_in_ext;
  logic [VALUE_WIDTH-1:0]              val_sel;
  logic [hklc_pkg::VALUE_EXT_W-1:0]    val_sel_ext;
  logic [IDX_W-1:0]                    slot_sel;
  logic [hklc_pkg::IDX_EXT_W-1:0]      slot_sel_ext;
  logic [hklc_pkg::CNT_EXT_W-1:0]      occ_ext;
  logic [IDX_W-1:0]                    slot_fill;
  logic                                out_free;

  tok_t tok_seed;
  tok_t tok_chain [ENTRIES];
  tok_t tok_fin;
  cmd_t cmd;

  always_comb begin
    tok_seed             = '0;
    tok_seed.old_time    = '1;
  end

  for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
    hklc_cell #(
      .ENTRIES     (ENTRIES),
      .VALUE_WIDTH (VALUE_WIDTH),
      .SLOT        (i),
      .tok_t       (tok_t),
      .cmd_t       (cmd_t)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .key_i (key_r),
      .tok_i ((i == 0) ? tok_seed : tok_chain[(i == 0) ? 0 : i - 1]),
      .tok_o (tok_chain[i]),
      .cmd_i (cmd)
    );
  end

  assign tok_fin     = tok_chain[ENTRIES-1];
  assign in_stall    = (state_r != ST_IDLE);
  assign out_free    = !out_valid_r || !out_stall;
  assign hash_new    = (acc_r << hklc_pkg::HASH_SHIFT) + acc_r + W'(in_key_byte);
  assign word_in_ext = hklc_pkg::VALUE_EXT_W'(in_result_word);
  assign slot_fill   = tok_fin.empty ? tok_fin.empty_idx : tok_fin.old_idx;
  assign val_sel_ext  = hklc_pkg::VALUE_EXT_W'(val_sel);
  assign slot_sel_ext = hklc_pkg::IDX_EXT_W'(slot_sel);
  assign occ_ext      = hklc_pkg::CNT_EXT_W'(occ_nxt);
  assign out_word_nxt = val_sel_ext[W-1:0];
  assign out_slot_nxt = slot_sel_ext[3:0];
  assign out_occ_nxt  = occ_ext[4:0];

  always_comb begin
    state_nxt     = state_r;
    acc_nxt       = acc_r;
    key_nxt       = key_r;
    ins_nxt       = ins_r;
    clr_nxt       = clr_r;
    word_nxt      = word_r;
    tick_nxt      = tick_r;
    cnt_nxt       = cnt_r;
    lookups_nxt   = lookups_r;
    hits_nxt      = hits_r;
    misses_nxt    = misses_r;
    occ_nxt       = occ_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_hit_nxt   = 1'b0;
    out_cnt_nxt   = '0;
    val_sel       = '0;
    slot_sel      = '0;
    cmd.kind      = hklc_pkg::CMD_NONE;
    cmd.slot      = '0;
    cmd.key       = key_r;
    cmd.value     = word_r;
    cmd.tick      = tick_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_opcode) inside
            hklc_pkg::OP_CLEAR: begin
              acc_nxt   = hklc_pkg::HASH_SEED;
              clr_nxt   = 1'b1;
              state_nxt = ST_APPLY;
            end
            hklc_pkg::OP_LOOKUP, hklc_pkg::OP_INSERT: begin
              if (!in_key_last) begin
                acc_nxt = hash_new;
              end else begin
                acc_nxt   = hklc_pkg::HASH_SEED;
                key_nxt   = hash_new;
                ins_nxt   = (in_opcode == hklc_pkg::OP_INSERT);
                word_nxt  = word_in_ext[VALUE_WIDTH-1:0];
                tick_nxt  = in_tick_now;
                cnt_nxt   = '0;
                state_nxt = ST_SEARCH;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SEARCH: begin
        cnt_nxt = cnt_r + IDX_W'(1);
        if (cnt_r == IDX_W'(ENTRIES - 1)) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
          if (clr_r) begin
            clr_nxt     = 1'b0;
            cmd.kind    = hklc_pkg::CMD_CLEAR;
            lookups_nxt = '0;
            hits_nxt    = '0;
            misses_nxt  = '0;
            occ_nxt     = '0;
          end else if (!ins_r) begin
            lookups_nxt = lookups_r + 32'd1;
            if (tok_fin.match) begin
              hits_nxt    = hits_r + 32'd1;
              cmd.kind    = hklc_pkg::CMD_HIT;
              cmd.slot    = tok_fin.match_idx;
              out_hit_nxt = 1'b1;
              val_sel     = tok_fin.match_value;
              out_cnt_nxt = tok_fin.match_hits + 32'd1;
              slot_sel    = tok_fin.match_idx;
            end else begin
              misses_nxt = misses_r + 32'd1;
            end
          end else if (tok_fin.match) begin
            cmd.kind    = hklc_pkg::CMD_UPDATE;
            cmd.slot    = tok_fin.match_idx;
            out_hit_nxt = 1'b1;
            val_sel     = word_r;
            out_cnt_nxt = tok_fin.match_hits;
            slot_sel    = tok_fin.match_idx;
          end else begin
            cmd.kind = hklc_pkg::CMD_FILL;
            cmd.slot = slot_fill;
            val_sel  = word_r;
            slot_sel = slot_fill;
            if (tok_fin.empty && (occ_r < CNT_W'(ENTRIES))) begin
              occ_nxt = occ_r + CNT_W'(1);
            end
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      acc_r       <= hklc_pkg::HASH_SEED;
      clr_r       <= 1'b0;
      lookups_r   <= '0;
      hits_r      <= '0;
      misses_r    <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      acc_r       <= acc_nxt;
      clr_r       <= clr_nxt;
      lookups_r   <= lookups_nxt;
      hits_r      <= hits_nxt;
      misses_r    <= misses_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r    <= key_nxt;
    ins_r    <= ins_nxt;
    word_r   <= word_nxt;
    tick_r   <= tick_nxt;
    cnt_r    <= cnt_nxt;
    if (out_free && (state_r == ST_APPLY)) begin
      out_hit_r     <= out_hit_nxt;
      out_word_r    <= out_word_nxt;
      out_cnt_r     <= out_cnt_nxt;
      out_slot_r    <= out_slot_nxt;
      out_lookups_r <= lookups_nxt;
      out_hits_r    <= hits_nxt;
      out_misses_r  <= misses_nxt;
      out_occ_r     <= out_occ_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_hit             = out_hit_r;
  assign out_stored_word     = out_word_r;
  assign out_entry_hit_count = out_cnt_r;
  assign out_slot_used       = out_slot_r;
  assign out_lookups_total   = out_lookups_r;
  assign out_hits_total      = out_hits_r;
  assign out_misses_total    = out_misses_r;
  assign out_occupancy       = out_occ_r;

endmodule

FILE: rtl/hklc_checker.sv
// Port-level checker for the hashed key LRU result cache, with its bind.
`include "hashed_key_lru_result_cache_macros.svh"

module hklc_checker #(
  parameter int ENTRIES = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_hit,
  input logic [31:0] out_stored_word,
  input logic [31:0] out_entry_hit_count,
  input logic [31:0] out_lookups_total,
  input logic [31:0] out_hits_total,
  input logic [31:0] out_misses_total,
  input logic [4:0]  out_occupancy
);

  `HKLC_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
    out_valid && $stable(out_stored_word) && $stable(out_lookups_total),
    "stalled result transfer changed")

  `HKLC_ASSERT_NOW(a_occ_bound, out_valid,
    32'(out_occupancy) <= 32'(ENTRIES),
    "occupancy above table capacity")

  `HKLC_ASSERT_NOW(a_miss_count, out_valid && !out_hit,
    out_entry_hit_count == 32'd0,
    "miss reports a nonzero entry hit count")

  `HKLC_ASSERT_NOW(a_total_sum, out_valid,
    (out_hits_total + out_misses_total) == out_lookups_total,
    "hit and miss totals do not add up to lookups")

endmodule

bind hashed_key_lru_result_cache hklc_checker #(.ENTRIES(ENTRIES)) u_hklc_checker (.*);
